FILE: design/ascii_integer_parser_macros.svh
// Assertion macros shared by the checker of the integer parser.
// Depends on nothing; included by files that assert.
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

// Overlapping implication, switched off while reset is high.
`define AIP_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication that also holds during reset.
`define AIP_ASSERT_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

FILE: design/aip_pkg.sv
// Package of the integer parser: constants, codes and the classified word type.
// Depends on nothing; used by every module of the parser.
package aip_pkg;

   localparam logic [15:0] MAX_CHARS   = 16'hFFFF;
   localparam int          QUEUE_DEPTH = 4;
   localparam int          QUEUE_AW    = 2;

   localparam logic [5:0] BASE_RESET = 6'd10;
   localparam logic [5:0] BASE_AUTO  = 6'd0;
   localparam logic [5:0] RADIX_HEX  = 6'd16;
   localparam logic [5:0] RADIX_OCT  = 6'd8;
   localparam logic [5:0] RADIX_DEC  = 6'd10;

   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_LX    = 8'h78;
   localparam logic [7:0] CH_UX    = 8'h58;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] UPPER_OFS = 8'd55;
   localparam logic [7:0] LOWER_OFS = 8'd87;

   typedef struct packed {
      logic [5:0] digit;
      logic       digit_ok;
      logic       blank;
      logic       plus;
      logic       minus;
      logic       is_x;
      logic       is_zero;
      logic       last;
   } char_class_type;

endpackage

FILE: design/aip_channels.sv
// Channel interfaces of the integer parser: request, response and register write.
// Depends on nothing.
interface aip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;
   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

interface aip_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [15:0] end_offset;
   modport source (output valid, output value, output end_offset, input ready);
   modport sink (input valid, input value, input end_offset, output ready);
endinterface

interface aip_csr_if;
   logic       valid;
   logic       ready;
   logic [5:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/ascii_integer_parser.sv
// Streaming ASCII to 64-bit integer parser, one character word per cycle while the queue is not full.
// A last word is written into the queue, popped by the back, and then held in the response register.
// Throughput: one word per cycle through the multiply-accumulate in the back;
// a stalled response holds the back at the next last word while the four-word queue fills.
// Reset (synchronous) empties the queue, clears the parse state and sets the radix to 10.
module ascii_integer_parser
   import aip_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   aip_req_if.sink   req_chan,
   aip_rsp_if.source rsp_chan,
   aip_csr_if.sink   csr_chan
);

   logic           push;
   char_class_type push_data;
   logic           queue_full;
   logic           pop;
   char_class_type pop_data;
   logic           not_empty;

   aip_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   aip_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .not_empty (not_empty)
   );

   aip_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (not_empty),
      .q_data   (pop_data),
      .q_pop    (pop),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

endmodule

FILE: design/aip_queue.sv
// Short queue of classified words between the front and back of the parser.
// Depends on aip_pkg.
module aip_queue
   import aip_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  char_class_type push_data,
   output logic           full,
   input  logic           pop,
   output char_class_type pop_data,
   output logic           not_empty
);

   char_class_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wr_ptr_ff;
   logic [QUEUE_AW-1:0]       rd_ptr_ff;
   logic [QUEUE_AW:0]         count_ff;
   logic [QUEUE_AW:0]         count_in;

   assign full      = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: design/aip_front.sv
// Front of the integer parser: takes request words and classifies each character.
// Depends on aip_pkg and the request channel interface.
module aip_front
   import aip_pkg::*;
(
   aip_req_if.sink        req_chan,
   input  logic           queue_full,
   output logic           push,
   output char_class_type push_data
);

   logic [7:0] c;
   logic       is_dec;
   logic       is_up;
   logic       is_low;
   logic [5:0] dval;

   assign c      = req_chan.char_code;
   assign is_dec = (c >= CH_ZERO) && (c <= CH_NINE);
   assign is_up  = (c >= CH_UA) && (c <= CH_UZ);
   assign is_low = (c >= CH_LA) && (c <= CH_LZ);

   always_comb begin
      dval = 6'(c - CH_ZERO);
      if (is_up) begin
         dval = 6'(c - UPPER_OFS);
      end else if (is_low) begin
         dval = 6'(c - LOWER_OFS);
      end
   end

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   assign push_data.digit    = dval;
   assign push_data.digit_ok = is_dec || is_up || is_low;
   assign push_data.blank    = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   assign push_data.plus     = (c == CH_PLUS);
   assign push_data.minus    = (c == CH_MINUS);
   assign push_data.is_x     = (c == CH_LX) || (c == CH_UX);
   assign push_data.is_zero  = (c == CH_ZERO);
   assign push_data.last     = req_chan.last;

endmodule

FILE: design/aip_back.sv
// Back of the integer parser: runs the parse state machine, holds the radix register
// and the response register. Depends on aip_pkg and the response and write interfaces.
module aip_back
   import aip_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  char_class_type q_data,
   output logic           q_pop,
   aip_rsp_if.source      rsp_chan,
   aip_csr_if.sink        csr_chan
);

   localparam logic [2:0] PH_SPACE  = 3'd0;
   localparam logic [2:0] PH_START  = 3'd1;
   localparam logic [2:0] PH_ZERO   = 3'd2;
   localparam logic [2:0] PH_DIGITS = 3'd3;
   localparam logic [2:0] PH_DONE   = 3'd4;

   logic [5:0]  base_ff;
   logic [2:0]  phase_ff;
   logic [2:0]  phase_in;
   logic        neg_ff;
   logic        neg_in;
   logic [5:0]  radix_ff;
   logic [5:0]  radix_in;
   logic [63:0] acc_ff;
   logic [63:0] acc_in;
   logic [15:0] cnt_ff;
   logic [15:0] cnt_in;
   logic        rsp_valid_ff;
   logic [63:0] res_acc_ff;
   logic        res_neg_ff;
   logic [15:0] res_cnt_ff;
   logic        take;
   logic        start;
   logic        digit_go;
   logic [63:0] prod;

   assign q_pop = q_valid && (!q_data.last || !rsp_valid_ff || rsp_chan.ready);

   always_comb begin
      phase_in = phase_ff;
      neg_in   = neg_ff;
      radix_in = radix_ff;
      acc_in   = acc_ff;
      take     = 1'b0;
      start    = 1'b0;
      digit_go = 1'b0;
      case (phase_ff)
         PH_SPACE: begin
            if (q_data.blank) begin
               take = 1'b1;
            end else if (q_data.plus || q_data.minus) begin
               neg_in   = q_data.minus;
               take     = 1'b1;
               phase_in = PH_START;
            end else begin
               start = 1'b1;
            end
         end
         PH_START: begin
            start = 1'b1;
         end
         PH_ZERO: begin
            phase_in = PH_DIGITS;
            if (q_data.is_x) begin
               radix_in = RADIX_HEX;
               take     = 1'b1;
            end else begin
               digit_go = 1'b1;
            end
         end
         PH_DIGITS: begin
            digit_go = 1'b1;
         end
         default: begin
         end
      endcase
      if (start) begin
         if (((base_ff == BASE_AUTO) || (base_ff == RADIX_HEX)) && q_data.is_zero) begin
            radix_in = (base_ff == BASE_AUTO) ? RADIX_OCT : RADIX_HEX;
            take     = 1'b1;
            phase_in = PH_ZERO;
         end else begin
            radix_in = (base_ff == BASE_AUTO) ? RADIX_DEC : base_ff;
            phase_in = PH_DIGITS;
            digit_go = 1'b1;
         end
      end
      prod = acc_ff * {58'd0, radix_in};
      if (digit_go) begin
         if (q_data.digit_ok && (q_data.digit < radix_in)) begin
            acc_in = prod + {58'd0, q_data.digit};
            take   = 1'b1;
         end else begin
            phase_in = PH_DONE;
         end
      end
      cnt_in = (take && (cnt_ff != MAX_CHARS)) ? cnt_ff + 16'd1 : cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= BASE_RESET;
         phase_ff     <= PH_SPACE;
         neg_ff       <= 1'b0;
         radix_ff     <= '0;
         acc_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            base_ff <= csr_chan.data;
         end
         if (q_pop && q_data.last) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (q_pop) begin
            if (q_data.last) begin
               phase_ff <= PH_SPACE;
               neg_ff   <= 1'b0;
               radix_ff <= '0;
               acc_ff   <= '0;
               cnt_ff   <= '0;
            end else begin
               phase_ff <= phase_in;
               neg_ff   <= neg_in;
               radix_ff <= radix_in;
               acc_ff   <= acc_in;
               cnt_ff   <= cnt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_data.last) begin
         res_acc_ff <= acc_in;
         res_neg_ff <= neg_in;
         res_cnt_ff <= cnt_in;
      end
   end

   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.value      = res_neg_ff ? (64'd0 - res_acc_ff) : res_acc_ff;
   assign rsp_chan.end_offset = res_cnt_ff;

endmodule

FILE: design/aip_checker.sv
// Port-level checks of the integer parser, bound to the top level.
// Depends on the assertion macro header.
`include "ascii_integer_parser_macros.svh"

module aip_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_value,
   input logic [15:0] rsp_end_offset
);

   logic        rsp_stall;
   logic [79:0] rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_word  = {rsp_value, rsp_end_offset};

   `AIP_ASSERT_NEXT(a_rsp_idle_after_reset, clock, reset, !rsp_valid)
   `AIP_ASSERT_NEXT(a_req_ready_after_reset, clock, reset, req_ready)
   `AIP_ASSERT_IMPL(a_rsp_hold, clock, reset, rsp_stall, ##1 (rsp_valid && $stable(rsp_word)))
   `AIP_ASSERT_IMPL(a_empty_is_zero, clock, reset, rsp_valid && (rsp_end_offset == 16'd0), rsp_value == 64'd0)

endmodule

bind ascii_integer_parser aip_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_value      (rsp_chan.value),
   .rsp_end_offset (rsp_chan.end_offset)
);
